/* design/lpe_pkg.sv */
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared sizes, codes, state type and the rotate start table of the LED
// pattern engine.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int LED_BYTES  = 36;
  localparam int MAX_FRAMES = 32;

  localparam int IDX_W     = $clog2(LED_BYTES);
  localparam int FRM_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W     = ($clog2(MAX_FRAMES + 1) > 6) ? $clog2(MAX_FRAMES + 1) : 6;
  localparam int FB_DEPTH  = MAX_FRAMES * LED_BYTES;
  localparam int FB_AW     = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int PIX_AW    = IDX_W + 1;
  localparam int PIX_DEPTH = 2 ** PIX_AW;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_REPEAT = 3'd3;
  localparam logic [2:0] OP_ROTATE = 3'd4;

  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_FRAME_TIME  = 2'd1;
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_AMT,
    ST_RUN
  } state_t;

  typedef logic [IDX_W-1:0] src_tbl_t [256];

  // source index of output byte zero for each signed rotate amount
  function automatic src_tbl_t build_src_tbl();
    src_tbl_t t;
    int       r;
    int       mag;
    for (int a = 0; a < 256; a++) begin
      if (a < 128) begin
        r = a % LED_BYTES;
      end else begin
        mag = (256 - a) % LED_BYTES;
        r   = (LED_BYTES - mag) % LED_BYTES;
      end
      t[a] = IDX_W'((LED_BYTES - r) % LED_BYTES);
    end
    return t;
  endfunction

  localparam src_tbl_t SRC_TBL = build_src_tbl();

endpackage

/* design/led_pattern_engine.sv */
// ----------------------------------------------------------------------------
// led_pattern_engine
// Frame program memory plus a double-banked colour buffer; an executed frame
// reads the old bank, applies the frame operation and writes the new bank
// while streaming every byte out.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  input     in_kind in_frame_addr in_byte_addr           start & !busy
//            in_opcode in_value
//  result    out_led_byte out_byte_index out_last         out_valid, one cycle
//  config    cfg_index cfg_wdata                          cfg_valid & cfg_ready
//
//  A write, restart or tick that runs no frame leaves busy low. A tick that runs
//  a frame keeps busy high through the fetch, amount and run states (data byte
//  zero, then one buffer byte per cycle through the single read port of each
//  memory); results follow one per cycle via the pipeline and output registers.
//  Reset is synchronous and needs no clearing pass: the colour buffer reads as
//  zero until the first frame has been written, and the frame data memory is
//  not cleared. The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module led_pattern_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_frame_addr,
  input  logic [5:0]  in_byte_addr,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  output logic [7:0]  out_led_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W  = lpe_pkg::IDX_W;
  localparam int FRM_W  = lpe_pkg::FRM_W;
  localparam int CNT_W  = lpe_pkg::CNT_W;
  localparam int FB_AW  = lpe_pkg::FB_AW;
  localparam int PIX_AW = lpe_pkg::PIX_AW;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(lpe_pkg::LED_BYTES - 1);

  lpe_pkg::state_t state_r, state_nxt;

  logic              enable_r;
  logic [15:0]       frame_time_r;
  logic [5:0]        frame_count_r;

  logic [2:0]        opc_r [lpe_pkg::MAX_FRAMES];
  logic [FRM_W-1:0]  cur_r;
  logic [7:0]        rep_r;
  logic [15:0]       ticks_r;
  logic              run_now_r;

  logic [2:0]        op_r;
  logic [FB_AW-1:0]  fb_addr_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  src_r;
  logic              bank_r;
  logic              buf_ok_r;

  logic              p_v_r;
  logic [IDX_W-1:0]  p_j_r;
  logic              p_wb_r;
  logic              p_ok_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  logic              acc;
  logic              is_tick;
  logic [15:0]       ticks_inc;
  logic              fire;
  logic [CNT_W-1:0]  cnt;
  logic [FRM_W-1:0]  cf_eff;
  logic [FRM_W-1:0]  cur_adv;
  logic [2:0]        op_eff;
  logic              wr_frame_ok;
  logic              wr_byte_ok;

  logic              fb_we;
  logic [FB_AW-1:0]  fb_waddr;
  logic              fb_re;
  logic [7:0]        fb_rdata;
  logic              pix_re;
  logic [PIX_AW-1:0] pix_raddr;
  logic [PIX_AW-1:0] pix_waddr;
  logic [7:0]        pix_rdata;
  logic [7:0]        old_byte;
  logic [7:0]        new_byte;
  logic              run_step;

  assign acc       = start & ~busy;
  assign cfg_ready = 1'b1;
  assign is_tick   = in_kind == lpe_pkg::KIND_TICK;

  assign ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign fire      = acc & is_tick & enable_r & (run_now_r | (ticks_inc >= frame_time_r));

  // effective frame count and the frame that is due
  always_comb begin
    if (frame_count_r == 6'd0) begin
      cnt = CNT_W'(1);
    end else if (CNT_W'(frame_count_r) > CNT_W'(lpe_pkg::MAX_FRAMES)) begin
      cnt = CNT_W'(lpe_pkg::MAX_FRAMES);
    end else begin
      cnt = CNT_W'(frame_count_r);
    end
    cf_eff = (CNT_W'(cur_r) >= cnt) ? '0 : cur_r;
    cur_adv = ((CNT_W'(cf_eff) + CNT_W'(1)) >= cnt) ? '0 : cf_eff + FRM_W'(1);
    op_eff = opc_r[cf_eff];
  end

  assign wr_frame_ok = CNT_W'(in_frame_addr) < CNT_W'(lpe_pkg::MAX_FRAMES);
  assign wr_byte_ok  = 7'(in_byte_addr) < 7'(lpe_pkg::LED_BYTES);
  assign fb_we       = acc & (in_kind == lpe_pkg::KIND_WRITE) & wr_frame_ok & wr_byte_ok;
  assign fb_waddr    = FB_AW'(FB_AW'(in_frame_addr[FRM_W-1:0]) * FB_AW'(lpe_pkg::LED_BYTES))
                     + FB_AW'(in_byte_addr);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpe_pkg::ST_IDLE:  if (fire) state_nxt = lpe_pkg::ST_FETCH;
      lpe_pkg::ST_FETCH: state_nxt = lpe_pkg::ST_AMT;
      lpe_pkg::ST_AMT:   state_nxt = lpe_pkg::ST_RUN;
      lpe_pkg::ST_RUN:   if (j_r == LAST_IDX) state_nxt = lpe_pkg::ST_IDLE;
      default:           state_nxt = lpe_pkg::ST_IDLE;
    endcase
  end

  // memory controls per state
  always_comb begin
    fb_re    = 1'b0;
    pix_re   = 1'b0;
    run_step = 1'b0;
    busy     = 1'b1;
    case (state_r)
      lpe_pkg::ST_IDLE:  busy = 1'b0;
      lpe_pkg::ST_FETCH: fb_re = 1'b1;
      lpe_pkg::ST_AMT:   ;
      lpe_pkg::ST_RUN: begin
        fb_re    = 1'b1;
        pix_re   = 1'b1;
        run_step = 1'b1;
      end
      default:           busy = 1'b0;
    endcase
  end

  assign pix_raddr = {bank_r, src_r};
  assign pix_waddr = {p_wb_r, p_j_r};

  lpe_ram #(
    .WIDTH (8),
    .DEPTH (lpe_pkg::FB_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (in_value),
    .re    (fb_re),
    .raddr (fb_addr_r),
    .rdata (fb_rdata)
  );

  lpe_ram #(
    .WIDTH (8),
    .DEPTH (lpe_pkg::PIX_DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (p_v_r),
    .waddr (pix_waddr),
    .wdata (new_byte),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // frame operation on one byte
  always_comb begin
    old_byte = p_ok_r ? pix_rdata : 8'd0;
    case (op_r)
      lpe_pkg::OP_LOAD: new_byte = fb_rdata;
      lpe_pkg::OP_ADD:  new_byte = old_byte + fb_rdata;
      default:          new_byte = old_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lpe_pkg::ST_IDLE;
      enable_r      <= 1'b0;
      frame_time_r  <= 16'd50;
      frame_count_r <= 6'd1;
      for (int i = 0; i < lpe_pkg::MAX_FRAMES; i++) begin
        opc_r[i] <= lpe_pkg::OP_NOP;
      end
      cur_r         <= '0;
      rep_r         <= 8'd0;
      ticks_r       <= 16'd0;
      run_now_r     <= 1'b1;
      bank_r        <= 1'b0;
      buf_ok_r      <= 1'b0;
      p_v_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpe_pkg::CFG_ENABLE:      enable_r      <= cfg_wdata[0];
          lpe_pkg::CFG_FRAME_TIME:  frame_time_r  <= cfg_wdata;
          lpe_pkg::CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[5:0];
          default:                  ;
        endcase
      end

      if (acc) begin
        case (in_kind)
          lpe_pkg::KIND_TICK: begin
            ticks_r <= fire ? 16'd0 : ticks_inc;
            if (fire) begin
              run_now_r <= op_eff == lpe_pkg::OP_REPEAT;
              if (op_eff != lpe_pkg::OP_REPEAT && rep_r != 8'd0) begin
                rep_r <= rep_r - 8'd1;
                cur_r <= cf_eff;
              end else begin
                cur_r <= cur_adv;
              end
            end
          end
          lpe_pkg::KIND_WRITE: begin
            if (wr_frame_ok) begin
              opc_r[in_frame_addr[FRM_W-1:0]] <= in_opcode;
            end
          end
          lpe_pkg::KIND_RESTART: begin
            cur_r     <= '0;
            rep_r     <= 8'd0;
            run_now_r <= 1'b1;
          end
          default: ;
        endcase
      end

      // repeat count comes from data byte zero
      if (state_r == lpe_pkg::ST_AMT && op_r == lpe_pkg::OP_REPEAT) begin
        rep_r <= (fb_rdata == 8'd0) ? 8'd0 : fb_rdata - 8'd1;
      end

      if (run_step && j_r == LAST_IDX) begin
        bank_r   <= ~bank_r;
        buf_ok_r <= 1'b1;
      end

      p_v_r       <= run_step;
      out_valid_r <= p_v_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (fire) begin
      op_r      <= op_eff;
      fb_addr_r <= FB_AW'(FB_AW'(cf_eff) * FB_AW'(lpe_pkg::LED_BYTES));
    end
    if (state_r == lpe_pkg::ST_AMT) begin
      j_r   <= '0;
      src_r <= (op_r == lpe_pkg::OP_ROTATE) ? lpe_pkg::SRC_TBL[fb_rdata] : '0;
    end
    if (run_step) begin
      j_r       <= j_r + IDX_W'(1);
      src_r     <= (src_r == LAST_IDX) ? '0 : src_r + IDX_W'(1);
      fb_addr_r <= fb_addr_r + FB_AW'(1);
      p_j_r     <= j_r;
      p_wb_r    <= ~bank_r;
      p_ok_r    <= buf_ok_r;
    end
    if (p_v_r) begin
      out_byte_r <= new_byte;
      out_idx_r  <= p_j_r;
      out_last_r <= p_j_r == LAST_IDX;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_byte   = out_byte_r;
  assign out_byte_index = 6'(out_idx_r);
  assign out_last       = out_last_r;

endmodule

/* design/lpe_ram.sv */
// ----------------------------------------------------------------------------
// lpe_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
